// ----- rtl/nmea_sentence_checker_defines.svh -----
// ----------------------------------------------------------------------------
// nmea_sentence_checker_defines.svh
// Assertion macros shared by the NMEA sentence checker RTL.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define NSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, character codes and per-byte line update for the NMEA checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsc_pkg;

	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_DOLLAR = 8'd36;
	localparam logic [7:0] CH_STAR   = 8'd42;
	localparam logic [7:0] CH_COMMA  = 8'd44;

	localparam int unsigned ID_LEN = 6;
	localparam int unsigned ID_NUM = 4;

	// $GPGSA, $GPGGA, $GNGSA, $GNGGA
	localparam logic [7:0] IGNORED_IDS [ID_NUM][ID_LEN] = '{
		'{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
		'{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
		'{8'h24, 8'h47, 8'h4E, 8'h47, 8'h53, 8'h41},
		'{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}
	};

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_IGNORED    = 2'd1,
		ST_MISMATCH   = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	// hex digit gathering after the latest star
	localparam logic [1:0] HP_NONE = 2'd0;
	localparam logic [1:0] HP_ONE  = 2'd1;
	localparam logic [1:0] HP_DONE = 2'd2;
	localparam logic [1:0] HP_BAD  = 2'd3;

	typedef struct packed {
		logic       has_bytes;
		logic       dollar;
		logic       held_cr;
		logic [7:0] run_xor;
		logic [7:0] xor_star;
		logic       star_seen;
		logic [1:0] after_star;
		logic [7:0] hex_value;
		logic [1:0] hex_prog;
		logic       id_done;
		logic [2:0] id_len;
		logic [3:0] id_flags;
	} line_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] computed;
		logic [7:0] received;
	} result_t;

	localparam line_t LINE_CLEAR = '{
		has_bytes:  1'b0,
		dollar:     1'b0,
		held_cr:    1'b0,
		run_xor:    8'h00,
		xor_star:   8'h00,
		star_seen:  1'b0,
		after_star: 2'd0,
		hex_value:  8'h00,
		hex_prog:   HP_NONE,
		id_done:    1'b0,
		id_len:     3'd0,
		id_flags:   4'hF
	};

	// bit 4 high for a hex digit, low bits its value
	function automatic logic [4:0] hex_digit(logic [7:0] b);
		logic [4:0] d;
		d = 5'd0;
		if (b >= 8'd48 && b <= 8'd57) begin
			d = {1'b1, 4'(b - 8'd48)};
		end else if (b >= 8'd65 && b <= 8'd70) begin
			d = {1'b1, 4'(b - 8'd55)};
		end else if (b >= 8'd97 && b <= 8'd102) begin
			d = {1'b1, 4'(b - 8'd87)};
		end
		return d;
	endfunction

	function automatic line_t take_byte(line_t s, logic [7:0] b);
		line_t      n;
		logic [4:0] d;
		logic       first;
		n = s;
		d = hex_digit(b);
		first = !s.has_bytes;

		if (first) begin
			n.has_bytes = 1'b1;
			n.dollar = (b == CH_DOLLAR);
		end

		if (b == CH_STAR) begin
			n.xor_star = s.run_xor;
			n.star_seen = 1'b1;
			n.after_star = 2'd0;
			n.hex_value = 8'h00;
			n.hex_prog = HP_NONE;
		end else if (s.star_seen) begin
			if (s.after_star == 2'd0) begin
				if (d[4]) begin
					n.hex_value = {4'h0, d[3:0]};
					n.hex_prog = HP_ONE;
				end else begin
					n.hex_prog = HP_BAD;
				end
			end else if (s.after_star == 2'd1 && s.hex_prog == HP_ONE) begin
				if (d[4]) begin
					n.hex_value = {s.hex_value[3:0], d[3:0]};
				end
				n.hex_prog = HP_DONE;
			end
			if (s.after_star < 2'd2) begin
				n.after_star = s.after_star + 2'd1;
			end
		end

		if (!first) begin
			n.run_xor = s.run_xor ^ b;
		end

		if (!s.id_done) begin
			if (b == CH_COMMA) begin
				n.id_done = 1'b1;
			end else begin
				for (int i = 0; i < ID_NUM; i++) begin
					if (s.id_len >= 3'(ID_LEN)) begin
						n.id_flags[i] = 1'b0;
					end else if (IGNORED_IDS[i][s.id_len] != b) begin
						n.id_flags[i] = 1'b0;
					end
				end
				if (s.id_len != 3'd7) begin
					n.id_len = s.id_len + 3'd1;
				end
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/nmea_sentence_checker.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Byte-serial NMEA 0183 line checker with XOR checksum verdict.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request (in_valid / in_ready, rx_byte).
// LF ends a line; a CR directly before the LF is dropped and empty lines give
// nothing. Every other line gives one verdict request on the output channel
// (out_valid / out_ready): line_status, computed_checksum, received_checksum.
// Throughput: one byte per cycle while in_ready is high, set by the single
// update of the line registers from the incoming byte. Latency: the verdict
// is valid in the cycle after its LF is accepted if the output slot is free.
// The result register is backed by a one-entry skid register, so bytes keep
// flowing while a verdict waits. in_ready drops only while the skid register
// is full, i.e. two verdicts are waiting; it returns in the cycle after the
// receiver takes one.
// Reset clears the line state and the valid flags of both result slots; the
// block is ready in the first cycle after arst_n rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_sentence_checker_defines.svh"

module nmea_sentence_checker
	import nsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] line_status,
	output logic [7:0] computed_checksum,
	output logic [7:0] received_checksum
);

	line_t   line_q;
	line_t   line_cr;
	line_t   line_d;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    in_acc;
	logic    is_lf;
	logic    push;
	logic    pop;
	logic    incomplete;

	assign in_ready = !skid_valid_q;
	assign in_acc   = in_valid && in_ready;
	assign is_lf    = (rx_byte == CH_LF);
	assign push     = in_acc && is_lf && line_q.has_bytes;
	assign pop      = out_valid_q && out_ready;

	always_comb begin
		line_cr = line_q;
		line_cr.held_cr = 1'b0;
		// a held CR not followed by LF is an ordinary byte
		if (line_q.held_cr) begin
			line_cr = take_byte(line_cr, CH_CR);
		end
		if (is_lf) begin
			line_d = LINE_CLEAR;
		end else if (rx_byte == CH_CR) begin
			line_d = line_cr;
			line_d.held_cr = 1'b1;
		end else begin
			line_d = take_byte(line_cr, rx_byte);
		end
	end

	always_comb begin
		incomplete = !line_q.dollar || !line_q.star_seen ||
			(line_q.after_star < 2'd2) || (line_q.hex_prog != HP_DONE);
		res.computed = 8'h00;
		res.received = 8'h00;
		if (incomplete) begin
			res.status = ST_INCOMPLETE;
		end else begin
			res.computed = line_q.xor_star;
			res.received = line_q.hex_value;
			if (line_q.xor_star != line_q.hex_value) begin
				res.status = ST_MISMATCH;
			end else if (line_q.id_done && line_q.id_len == 3'(ID_LEN) &&
				line_q.id_flags != 4'h0) begin
				res.status = ST_IGNORED;
			end else begin
				res.status = ST_ACCEPTED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_CLEAR;
		end else if (in_acc) begin
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload slots, steered as the control block above
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign line_status       = out_q.status;
	assign computed_checksum = out_q.computed;
	assign received_checksum = out_q.received;

	`NSC_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid slot full while output slot empty")
	`NSC_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_q && !out_ready, skid_valid_q,
		"verdict pushed into a stalled output was lost")
	`NSC_ASSERT_NOW(a_incomplete_zero,
		out_valid_q && out_q.status == ST_INCOMPLETE,
		out_q.computed == 8'h00 && out_q.received == 8'h00,
		"incomplete verdict carries nonzero checksums")
	`NSC_ASSERT_NEXT(a_lf_clears_line, in_acc && is_lf,
		!line_q.has_bytes && !line_q.held_cr && line_q.id_flags == 4'hF,
		"line state not cleared after LF")
	`NSC_ASSERT_NEXT(a_verdict_follows, push && !skid_valid_q, out_valid_q,
		"no verdict after a non-empty line")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence checker. A short table of lines
// comes first, then random sentences, broken sentences and noise. A line model
// inside the bench predicts each verdict that a table row does not fix itself,
// and verdicts are compared in order, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import nsc_pkg::*;

	localparam int CHAR_TARGET    = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT_RESULT = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam result_t NO_VERDICT      = '{ST_ACCEPTED, 8'h00, 8'h00};
	localparam result_t INCOMPLETE_ZERO = '{ST_INCOMPLETE, 8'h00, 8'h00};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] line_status;
	logic [7:0] computed_checksum;
	logic [7:0] received_checksum;

	// line model
	typedef struct packed {
		logic       open;
		logic       dollar;
		logic       cr_wait;
		logic [7:0] xor_acc;
		logic [7:0] xor_star;
		logic       star;
		logic [1:0] after;
		logic [7:0] hex;
		logic [1:0] hex_st;
		logic       id_done;
		logic [2:0] id_len;
		logic [3:0] id_hit;
	} sentence_t;

	localparam sentence_t SENTENCE_CLEAR = '{
		open: 1'b0, dollar: 1'b0, cr_wait: 1'b0, xor_acc: 8'h00, xor_star: 8'h00,
		star: 1'b0, after: 2'd0, hex: 8'h00, hex_st: HP_NONE, id_done: 1'b0,
		id_len: 3'd0, id_hit: 4'hF
	};

	typedef struct {
		int      lead;  // byte sent ahead of the text, -1 for none
		string   text;
		bit      typed;
		result_t want;
	} dir_row_t;

	// a string cannot carry a zero byte, hence the lead column
	dir_row_t dir_rows [] = '{
		'{-1,  "\n",               1'b0, NO_VERDICT},
		'{0,   "\n",               1'b1, INCOMPLETE_ZERO},
		'{255, "$*00\n",           1'b1, INCOMPLETE_ZERO},
		'{-1,  "$GPRMC,A*26\n",    1'b0, NO_VERDICT},
		'{-1,  "$GPRMC,A*26\015\n", 1'b0, NO_VERDICT},
		'{-1,  "$GPRMC,A*27\n",    1'b1, '{ST_MISMATCH, 8'h26, 8'h27}},
		'{-1,  "$GPGSA,1*5f\n",    1'b0, NO_VERDICT},
		'{-1,  "$GPGGA,*7A\n",     1'b0, NO_VERDICT},
		'{-1,  "$GNGSA,*70\n",     1'b0, NO_VERDICT},
		'{-1,  "$GNGGA,*64\015\n", 1'b0, NO_VERDICT},
		'{-1,  "$GPGSA*42\n",      1'b0, NO_VERDICT},
		'{-1,  "$GPGSAX,*36\n",    1'b0, NO_VERDICT},
		'{-1,  "$GPGS,*2F\n",      1'b0, NO_VERDICT},
		'{-1,  "$AB*3Z\n",         1'b0, NO_VERDICT},
		'{-1,  "$AB*3\n",          1'b1, INCOMPLETE_ZERO},
		'{-1,  "$AB\n",            1'b1, INCOMPLETE_ZERO},
		'{-1,  "$AB*G3\n",         1'b1, INCOMPLETE_ZERO},
		'{-1,  "GP*00\n",          1'b1, INCOMPLETE_ZERO},
		'{-1,  "$A*B*29\n",        1'b0, NO_VERDICT},
		'{-1,  "$A\015B*0E\n",     1'b0, NO_VERDICT},
		'{-1,  "\015\n",           1'b0, NO_VERDICT},
		'{-1,  "\015\015\n",       1'b1, INCOMPLETE_ZERO},
		'{-1,  "$*00\377\n",       1'b0, NO_VERDICT},
		'{-1,  "$\377*FF\n",       1'b0, NO_VERDICT}
	};

	sentence_t cur = SENTENCE_CLEAR;
	result_t   verdicts_due [$];
	bit        typed_on = 1'b0;
	result_t   typed_val = NO_VERDICT;
	bit        calm_window = 1'b0;
	int        chars_sent = 0;
	int        fault_count = 0;

	nmea_sentence_checker dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.line_status       (line_status),
		.computed_checksum (computed_checksum),
		.received_checksum (received_checksum)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int nibble_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10) return 8'h30 + {4'h0, n};
		return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
	endfunction

	task automatic absorb_char(input logic [7:0] c);
		int   nib;
		logic lead;
		nib = nibble_of(c);
		lead = !cur.open;
		if (lead) begin
			cur.open = 1'b1;
			cur.dollar = (c == CH_DOLLAR);
		end
		if (c == CH_STAR) begin
			// restart the checksum capture on every star, the last one wins
			cur.xor_star = cur.xor_acc;
			cur.star = 1'b1;
			cur.after = 2'd0;
			cur.hex = 8'h00;
			cur.hex_st = HP_NONE;
		end else if (cur.star) begin
			if (cur.after == 2'd0) begin
				if (nib >= 0) begin
					cur.hex = 8'(nib);
					cur.hex_st = HP_ONE;
				end else begin
					cur.hex_st = HP_BAD;
				end
			end else if (cur.after == 2'd1 && cur.hex_st == HP_ONE) begin
				if (nib >= 0) begin
					cur.hex = {cur.hex[3:0], 4'(nib)};
				end
				cur.hex_st = HP_DONE;
			end
			if (cur.after != 2'd2) begin
				cur.after = cur.after + 2'd1;
			end
		end
		if (!lead) begin
			cur.xor_acc = cur.xor_acc ^ c;
		end
		if (!cur.id_done) begin
			if (c == CH_COMMA) begin
				cur.id_done = 1'b1;
			end else begin
				for (int k = 0; k < ID_NUM; k++) begin
					if (cur.id_len >= ID_LEN) begin
						cur.id_hit[k] = 1'b0;
					end else if (IGNORED_IDS[k][cur.id_len] != c) begin
						cur.id_hit[k] = 1'b0;
					end
				end
				if (cur.id_len != 3'd7) begin
					cur.id_len = cur.id_len + 3'd1;
				end
			end
		end
	endtask

	task automatic predict_char(input logic [7:0] c, output bit fired, output result_t v);
		fired = 1'b0;
		v = NO_VERDICT;
		if (c != CH_LF) begin
			// a CR only joins the line once something other than LF follows it
			if (cur.cr_wait) begin
				cur.cr_wait = 1'b0;
				absorb_char(CH_CR);
			end
			if (c == CH_CR) begin
				cur.cr_wait = 1'b1;
			end else begin
				absorb_char(c);
			end
		end else begin
			if (cur.open) begin
				fired = 1'b1;
				if (!cur.dollar || !cur.star || cur.after != 2'd2 || cur.hex_st != HP_DONE) begin
					v.status = ST_INCOMPLETE;
				end else begin
					v.computed = cur.xor_star;
					v.received = cur.hex;
					if (cur.xor_star != cur.hex) begin
						v.status = ST_MISMATCH;
					end else if (cur.id_done && cur.id_len == 3'(ID_LEN) && cur.id_hit != 4'h0) begin
						v.status = ST_IGNORED;
					end else begin
						v.status = ST_ACCEPTED;
					end
				end
			end
			cur = SENTENCE_CLEAR;
		end
	endtask

	task automatic send_char(input logic [7:0] c);
		bit      fired;
		result_t v;
		if (!calm_window && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 28);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		// hold the request until the checker takes it
		do @(posedge clk); while (!in_ready);
		chars_sent++;
		predict_char(c, fired, v);
		if (fired) begin
			verdicts_due = {verdicts_due, (typed_on ? typed_val : v)};
		end
	endtask

	initial begin : stimulus
		int         roll;
		int         kind;
		int         span;
		int         len;
		bit         lower;
		logic [7:0] sum;
		logic [7:0] bad;
		logic [7:0] line_buf [$];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			typed_on = dir_rows[r].typed;
			typed_val = dir_rows[r].want;
			if (dir_rows[r].lead >= 0) begin
				send_char(8'(dir_rows[r].lead));
			end
			for (int k = 0; k < dir_rows[r].text.len(); k++) begin
				send_char(dir_rows[r].text[k]);
			end
		end
		typed_on = 1'b0;

		while (chars_sent < CHAR_TARGET) begin
			calm_window = (chars_sent >= 900 && chars_sent < 1300);
			line_buf.delete();
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				line_buf = {line_buf, CH_DOLLAR};
				kind = $urandom_range(0, 5);
				if (kind < ID_NUM) begin
					for (int j = 1; j < ID_LEN; j++) begin
						line_buf = {line_buf, IGNORED_IDS[kind][j]};
					end
				end else begin
					span = $urandom_range(1, 7);
					repeat (span) line_buf = {line_buf, 8'($urandom_range(65, 90))};
				end
				span = $urandom_range(0, 4);
				repeat (span) begin
					line_buf = {line_buf, CH_COMMA};
					len = $urandom_range(0, 6);
					repeat (len) line_buf = {line_buf, 8'($urandom_range(32, 126))};
				end
				sum = 8'h00;
				for (int j = 1; j < line_buf.size(); j++) begin
					sum ^= line_buf[j];
				end
				line_buf = {line_buf, CH_STAR};
				roll = $urandom_range(0, 99);
				lower = 1'($urandom_range(0, 1));
				if (roll < 70) begin
					line_buf = {line_buf, hex_char(sum[7:4], lower)};
					line_buf = {line_buf, hex_char(sum[3:0], lower)};
				end else if (roll < 80) begin
					bad = sum ^ 8'($urandom_range(1, 255));
					line_buf = {line_buf, hex_char(bad[7:4], lower)};
					line_buf = {line_buf, hex_char(bad[3:0], lower)};
				end else if (roll < 88) begin
					// single digit followed by a letter past F
					line_buf = {line_buf, hex_char(sum[3:0], lower)};
					line_buf = {line_buf, 8'($urandom_range(71, 90))};
				end else if (roll < 94) begin
					if ($urandom_range(0, 1) != 0) begin
						line_buf = {line_buf, hex_char(sum[3:0], lower)};
					end
				end else begin
					line_buf = {line_buf, 8'($urandom_range(0, 255))};
					line_buf = {line_buf, hex_char(sum[3:0], lower)};
				end
				if ($urandom_range(0, 1) != 0) begin
					line_buf = {line_buf, CH_CR};
				end
				line_buf = {line_buf, CH_LF};
			end else begin
				// noise, sometimes left open to run into the next line
				if ($urandom_range(0, 1) != 0) begin
					line_buf = {line_buf, CH_DOLLAR};
				end
				span = $urandom_range(0, 16);
				repeat (span) line_buf = {line_buf, 8'($urandom_range(0, 255))};
				if ($urandom_range(0, 3) != 0) begin
					line_buf = {line_buf, CH_LF};
				end
			end
			foreach (line_buf[p]) begin
				send_char(line_buf[p]);
			end
		end
		calm_window = 1'b0;
		in_valid <= 1'b0;

		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (fault_count == 0) begin
			$display("[nmea_sentence_checker] OK");
		end else begin
			$display("[nmea_sentence_checker] ERROR");
		end
		$finish;
	end

	initial begin : verdict_sink
		int      hold_left;
		int      results_seen;
		result_t want;
		hold_left = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (verdicts_due.size() == 0) begin
					if (fault_count < 10) begin
						$display("unexpected verdict: status %0d computed %02h received %02h",
							line_status, computed_checksum, received_checksum);
					end
					fault_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (want.status != line_status || want.computed != computed_checksum ||
						want.received != received_checksum) begin
						if (fault_count < 10) begin
							$display("verdict mismatch: expected %0d/%02h/%02h, got %0d/%02h/%02h",
								want.status, want.computed, want.received,
								line_status, computed_checksum, received_checksum);
						end
						fault_count++;
					end
				end
				// back off long enough for the checker to fill up and stall its input
				if (results_seen == HOLD_AT_RESULT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm_window || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[nmea_sentence_checker] ERROR");
		$finish;
	end

endmodule
